### sv/nearest_palette_color_search_defines.svh
// Assertion macros used by the checker of the palette search block.
// No dependencies; include by bare file name.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("npcs check failed (same cycle)");

// Next-cycle implication, disabled while reset is asserted.
`define NPCS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("npcs check failed (next cycle)");

`endif

### sv/npcs_pkg.sv
// Shared types, constants and helpers of the nearest palette colour search.
// No dependencies.
`timescale 1ns / 1ps

package npcs_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_IDX_W     = $clog2(PALETTE_DEPTH);
    localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
    localparam int IDX_EXT_W     = (PAL_IDX_W > 8) ? PAL_IDX_W : 8;
    localparam int ENTRY_CMP_W   = (CNT_W > 8) ? CNT_W : 8;
    localparam int SIZE_CMP_W    = (CNT_W > 9) ? CNT_W : 9;

    // largest distance is about 2.75e8, fits 29 bits
    localparam int DIST_W = 29;

    localparam logic [DIST_W-1:0] START_BEST   = DIST_W'(9999999);
    localparam logic [DIST_W-1:0] WEIGHT_RED   = DIST_W'(222784);
    localparam logic [DIST_W-1:0] WEIGHT_GREEN = DIST_W'(14400);
    localparam logic [DIST_W-1:0] WEIGHT_BLUE  = DIST_W'(1936);
    localparam logic [DIST_W-1:0] WEIGHT_ALPHA = DIST_W'(6750);

    // v / 15 == (v * 137) >> 11 for every 8-bit v
    localparam logic [15:0] DIV15_MUL = 16'd137;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN,
        ST_DONE
    } npcs_state_t;

    typedef struct packed {
        logic write;   // store s_argb_color at s_entry_index
        logic start;   // latch pixel and count, clear best
        logic issue;   // read next palette entry into the pipeline
        logic load;    // move nearest index into the output register
    } npcs_cmd_t;

    typedef struct packed {
        logic issue_done;
        logic pipe_empty;
        logic out_free;
    } npcs_status_t;

    typedef struct packed {
        logic [4:0] a;
        logic [4:0] r;
        logic [5:0] g;
        logic [4:0] b;
    } npcs_chan_t;

    function automatic logic [4:0] div15(input logic [7:0] v);
        logic [15:0] p;
        p = 16'(v) * DIV15_MUL;
        return p[15:11];
    endfunction

    function automatic npcs_chan_t reduce_color(input logic [31:0] c);
        npcs_chan_t ch;
        ch.a = div15(c[31:24]);
        ch.r = c[23:19];
        ch.g = c[15:10];
        ch.b = c[7:3];
        return ch;
    endfunction

endpackage

### sv/npcs_ctrl.sv
// Controller FSM of the nearest palette colour search.
// Depends on npcs_pkg; drives the datapath by npcs_cmd_t, reads npcs_status_t.
`timescale 1ns / 1ps

module npcs_ctrl import npcs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_mode,
    output logic         s_tready,
    output npcs_cmd_t    cmd,
    input  npcs_status_t status
);

    npcs_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_mode == MODE_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SEARCH;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                if (status.issue_done) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.issue = 1'b1;
                end
            end
            ST_DRAIN: begin
                if (status.pipe_empty) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (status.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/npcs_datapath.sv
// Datapath: palette memory, distance pipeline, best tracker, output register.
// Depends on npcs_pkg; steered by npcs_ctrl through npcs_cmd_t.
`timescale 1ns / 1ps

module npcs_datapath import npcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [8:0]         cfg_wr_data,
    input  logic [7:0]         s_entry_index,
    input  logic [31:0]        s_argb_color,
    input  npcs_cmd_t          cmd,
    output npcs_status_t       status,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_nearest_index
);

    logic [31:0] mem [PALETTE_DEPTH];

    logic [8:0]           size_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     addr_reg;
    npcs_chan_t           pix_reg;

    logic                 rd_v_reg;
    logic [PAL_IDX_W-1:0] rd_idx_reg;
    logic [31:0]          rd_data_reg;

    logic                 red_v_reg;
    logic [PAL_IDX_W-1:0] red_idx_reg;
    npcs_chan_t           red_reg;

    logic                 sq_v_reg;
    logic [PAL_IDX_W-1:0] sq_idx_reg;
    logic [9:0]           sq_r_reg, sq_r_next;
    logic [11:0]          sq_g_reg, sq_g_next;
    logic [9:0]           sq_b_reg, sq_b_next;
    logic [9:0]           sq_a_reg, sq_a_next;

    logic                 dist_v_reg;
    logic [PAL_IDX_W-1:0] dist_idx_reg;
    logic [DIST_W-1:0]    dist_reg, dist_next;

    logic [DIST_W-1:0]    best_reg;
    logic [PAL_IDX_W-1:0] nearest_reg;

    logic                 out_valid_reg;
    logic [7:0]           out_data_reg;

    logic [ENTRY_CMP_W-1:0] wr_slot;
    logic                   wr_ok;
    logic [SIZE_CMP_W-1:0]  size_ext;
    logic [IDX_EXT_W-1:0]   nearest_ext;
    logic [4:0]             d_r, d_b, d_a;
    logic [5:0]             d_g;

    // write slot range check and count saturation
    always_comb begin
        wr_slot  = ENTRY_CMP_W'(s_entry_index);
        wr_ok    = wr_slot < ENTRY_CMP_W'(PALETTE_DEPTH);
        size_ext = SIZE_CMP_W'(size_reg);
        if (size_ext > SIZE_CMP_W'(PALETTE_DEPTH)) begin
            count_next = CNT_W'(PALETTE_DEPTH);
        end else begin
            count_next = CNT_W'(size_ext);
        end
    end

    // absolute deltas and squares
    always_comb begin
        d_r = (pix_reg.r > red_reg.r) ? (pix_reg.r - red_reg.r) : (red_reg.r - pix_reg.r);
        d_g = (pix_reg.g > red_reg.g) ? (pix_reg.g - red_reg.g) : (red_reg.g - pix_reg.g);
        d_b = (pix_reg.b > red_reg.b) ? (pix_reg.b - red_reg.b) : (red_reg.b - pix_reg.b);
        d_a = (pix_reg.a > red_reg.a) ? (pix_reg.a - red_reg.a) : (red_reg.a - pix_reg.a);
        sq_r_next = 10'(d_r) * 10'(d_r);
        sq_g_next = 12'(d_g) * 12'(d_g);
        sq_b_next = 10'(d_b) * 10'(d_b);
        sq_a_next = 10'(d_a) * 10'(d_a);
    end

    // weighted sum
    always_comb begin
        dist_next = DIST_W'(sq_r_reg) * WEIGHT_RED
                  + DIST_W'(sq_g_reg) * WEIGHT_GREEN
                  + DIST_W'(sq_b_reg) * WEIGHT_BLUE
                  + DIST_W'(sq_a_reg) * WEIGHT_ALPHA;
    end

    // palette memory: one write, one registered read
    always_ff @(posedge aclk) begin
        if (cmd.write && wr_ok) begin
            mem[wr_slot[PAL_IDX_W-1:0]] <= s_argb_color;
        end
        if (cmd.issue) begin
            rd_data_reg <= mem[addr_reg[PAL_IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg      <= '0;
            addr_reg      <= '0;
            rd_v_reg      <= 1'b0;
            red_v_reg     <= 1'b0;
            sq_v_reg      <= 1'b0;
            dist_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            if (cmd.start) begin
                addr_reg <= '0;
            end else if (cmd.issue) begin
                addr_reg <= addr_reg + CNT_W'(1);
            end
            rd_v_reg   <= cmd.issue;
            red_v_reg  <= rd_v_reg;
            sq_v_reg   <= red_v_reg;
            dist_v_reg <= sq_v_reg;
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            pix_reg   <= reduce_color(s_argb_color);
            count_reg <= count_next;
        end
        rd_idx_reg   <= addr_reg[PAL_IDX_W-1:0];
        red_idx_reg  <= rd_idx_reg;
        red_reg      <= reduce_color(rd_data_reg);
        sq_idx_reg   <= red_idx_reg;
        sq_r_reg     <= sq_r_next;
        sq_g_reg     <= sq_g_next;
        sq_b_reg     <= sq_b_next;
        sq_a_reg     <= sq_a_next;
        dist_idx_reg <= sq_idx_reg;
        dist_reg     <= dist_next;
        if (cmd.start) begin
            best_reg    <= START_BEST;
            nearest_reg <= '0;
        end else if (dist_v_reg && (dist_reg < best_reg)) begin
            best_reg    <= dist_reg;
            nearest_reg <= dist_idx_reg;
        end
        if (cmd.load) begin
            out_data_reg <= nearest_ext[7:0];
        end
    end

    assign nearest_ext       = IDX_EXT_W'(nearest_reg);
    assign status.issue_done = addr_reg >= count_reg;
    assign status.pipe_empty = !(rd_v_reg || red_v_reg || sq_v_reg || dist_v_reg);
    assign status.out_free   = !out_valid_reg || m_tready;
    assign m_tvalid          = out_valid_reg;
    assign m_nearest_index   = out_data_reg;

endmodule

### sv/nearest_palette_color_search.sv
// Nearest palette colour search, top level. Write: no result. Query over
// N = min(palette_size, 256) entries: next item taken when the result shows.
// Throughput set by the single read port of the palette memory: one entry a cycle.
// aresetn (synchronous, active low) clears FSM, pipeline valids, output valid and
// palette_size; palette contents are undefined until written.
`timescale 1ns / 1ps

module nearest_palette_color_search import npcs_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // palette_size register write
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] entry_index, [39:8] argb_color
    input  logic [0:0]  s_tuser,   // [0] mode (0 write, 1 query)
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] nearest_index
);

    npcs_cmd_t    cmd;
    npcs_status_t status;

    // FSM: idle -> search (one read per cycle) -> drain pipeline -> hand off result
    npcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_mode   (s_tuser[0]),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    // Memory read, channel reduce, square, weight and sum, then compare
    // against the running best (strictly smaller wins, so ties keep the lower index).
    // The output register lets a new transaction in while a result waits.
    npcs_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_entry_index   (s_tdata[7:0]),
        .s_argb_color    (s_tdata[39:8]),
        .cmd             (cmd),
        .status          (status),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_nearest_index (m_tdata)
    );

endmodule

### sv/npcs_checker.sv
// Port-level checks of the nearest palette colour search, with its bind.
// Depends on nearest_palette_color_search_defines.svh and the top level.
`timescale 1ns / 1ps
`include "nearest_palette_color_search_defines.svh"

module npcs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    // stalled result holds
    `NPCS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // a query transaction makes the block busy in the next cycle
    `NPCS_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_tvalid && s_tready && s_tuser[0], !s_tready)

    // a palette write leaves the block ready
    `NPCS_ASSERT_NEXT(a_write_idle, aclk, aresetn, s_tvalid && s_tready && !s_tuser[0], s_tready)

    // a new result appears just as the block becomes ready again
    `NPCS_ASSERT_SAME(a_result_ready, aclk, aresetn, $rose(m_tvalid), s_tready)

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);

### tb/tb_nearest_palette_color_search.sv
// Self-checking bench for nearest_palette_color_search: palette writes and
// nearest-colour queries over several palette sizes, with a local predictor
// and a scoreboard. Depends on npcs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_nearest_palette_color_search;
    import npcs_pkg::*;

    // weights and seed of the distance search
    localparam int unsigned K_RED      = 222784;
    localparam int unsigned K_GREEN    = 14400;
    localparam int unsigned K_BLUE     = 1936;
    localparam int unsigned K_ALPHA    = 6750;
    localparam int unsigned BEST_SEED  = 9999999;
    // longest quiet stretch in a good run is a full 256-entry query plus
    // both sides' longest idle burst
    localparam int          QUIET_LIMIT = 4000;
    localparam int          REPORT_MAX  = 10;
    localparam int          RAND_PHASES = 12;
    localparam int          PHASE_ITEMS = 135;

    // one input transaction, packed as {s_tuser, s_tdata}
    typedef struct packed {
        logic        mode;
        logic [31:0] argb_color;
        logic [7:0]  entry_index;
    } palette_op_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [8:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata     = '0;
    logic [0:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [7:0]  m_tdata;

    palette_op_t pending[$];        // transactions waiting for the sender
    logic [7:0]  nearest_due[$];    // predicted indices, oldest first
    logic [31:0] palette_shadow[PALETTE_DEPTH];
    logic [8:0]  size_shadow;
    logic [31:0] gen_colours[PALETTE_DEPTH];   // palette as the generator sees it
    bit          idle_on = 1'b0;
    int          send_gap = 0;
    int          rcv_stall = 0;
    int          quiet_cycles = 0;
    int          fault_count = 0;

    nearest_palette_color_search dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int unsigned sq_diff(input int unsigned a, input int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return d * d;
    endfunction

    // Channels are reduced before squaring: red and blue keep 5 bits,
    // green 6 bits, alpha is divided by 15.
    function automatic int unsigned colour_distance(input logic [31:0] p,
                                                    input logic [31:0] e);
        return sq_diff(p[23:19], e[23:19]) * K_RED
             + sq_diff(p[15:10], e[15:10]) * K_GREEN
             + sq_diff(p[7:3],   e[7:3])   * K_BLUE
             + sq_diff(p[31:24] / 15, e[31:24] / 15) * K_ALPHA;
    endfunction

    // Strictly-smaller test keeps the lowest index on a tie; an empty
    // search leaves index 0. Sizes above the palette depth saturate.
    function automatic logic [7:0] nearest_entry(input logic [31:0] pixel);
        int unsigned span;
        int unsigned best;
        int unsigned d;
        logic [7:0]  pick;
        span = (size_shadow > PALETTE_DEPTH) ? PALETTE_DEPTH : size_shadow;
        best = BEST_SEED;
        pick = '0;
        for (int i = 0; i < span; i++) begin
            d = colour_distance(pixel, palette_shadow[i]);
            if (d < best) begin
                best = d;
                pick = i[7:0];
            end
        end
        return pick;
    endfunction

    // ---------------------------------------------------------------
    // Sender: presents queued transactions, with random idle bursts
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : sender
        palette_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            // previous transaction (if any) has gone; choose the next
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending.size() != 0) begin
                op = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {op.argb_color, op.entry_index};
                s_tuser  <= op.mode;
                if (idle_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 15);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Scoreboard: shadows register and palette, predicts on each query
    // transaction, checks each result transaction, drives m_tready and
    // runs the watchdog.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : scoreboard
        palette_op_t op;
        logic [7:0]  want;
        if (!aresetn) begin
            size_shadow = '0;
            rcv_stall = 0;
            quiet_cycles = 0;
            m_tready <= 1'b0;
        end else begin
            quiet_cycles++;
            if (cfg_wr_en) begin
                size_shadow = cfg_wr_data;
                quiet_cycles = 0;
            end
            if (s_tvalid && s_tready) begin
                quiet_cycles = 0;
                op = {s_tuser, s_tdata};
                if (op.mode == MODE_WRITE)
                    palette_shadow[op.entry_index] = op.argb_color;
                else
                    nearest_due.push_back(nearest_entry(op.argb_color));
            end
            if (m_tvalid && m_tready) begin
                quiet_cycles = 0;
                if (nearest_due.size() == 0) begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("%0t: unexpected result, nearest_index %0d",
                                 $realtime, m_tdata);
                end else begin
                    want = nearest_due.pop_front();
                    if (m_tdata !== want) begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display("%0t: nearest_index expected %0d, got %0d",
                                     $realtime, want, m_tdata);
                    end
                end
            end
            // receiver back-pressure
            if (rcv_stall > 0) begin
                rcv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                    rcv_stall = $urandom_range(1, 15);
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic queue_item(input logic mode, input logic [7:0] idx,
                              input logic [31:0] colour);
        palette_op_t op;
        op.mode        = mode;
        op.entry_index = idx;
        op.argb_color  = colour;
        pending.push_back(op);
        if (mode == MODE_WRITE)
            gen_colours[idx] = colour;
    endtask

    // Block is idle once every transaction has gone and every result has
    // come; the trailing wait covers the write path.
    task automatic settle();
        do @(negedge aclk);
        while (pending.size() != 0 || s_tvalid || nearest_due.size() != 0);
        repeat (10) @(posedge aclk);
    endtask

    task automatic write_size(input logic [8:0] v);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Writes often copy an existing colour so that ties turn up; queries
    // mix random pixels, exact palette hits, hits disturbed only in the
    // bits the reduction drops, one-bit neighbours and the extremes.
    task automatic random_item();
        logic [31:0] c;
        logic [31:0] hit;
        hit = gen_colours[PAL_IDX_W'($urandom_range(0, PALETTE_DEPTH - 1))];
        if ($urandom_range(0, 9) < 4) begin
            c = ($urandom_range(0, 3) == 0) ? hit : $urandom;
            queue_item(MODE_WRITE, 8'($urandom_range(0, 255)), c);
        end else begin
            case ($urandom_range(0, 4))
                0: c = $urandom;
                1: c = hit;
                2: c = hit ^ ($urandom & 32'h0007_0307);
                3: c = hit ^ (32'd1 << $urandom_range(0, 31));
                default: c = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            endcase
            queue_item(MODE_QUERY, 8'($urandom), c);
        end
    endtask

    initial begin : stimulus
        logic [8:0] sz;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // empty search, then seed a few entries including the top slot
        write_size(9'd0);
        queue_item(MODE_QUERY, 8'd0,   32'h0000_0000);
        queue_item(MODE_QUERY, 8'hFF,  32'hFFFF_FFFF);
        queue_item(MODE_WRITE, 8'd0,   32'h0000_0000);
        queue_item(MODE_WRITE, 8'd1,   32'hFFFF_FFFF);
        queue_item(MODE_WRITE, 8'd2,   32'h8040_2010);
        queue_item(MODE_WRITE, 8'd3,   32'h8040_2010);   // duplicate: tie with 2
        queue_item(MODE_WRITE, 8'hFF,  32'h1234_5678);
        settle();

        write_size(9'd4);
        queue_item(MODE_QUERY, 8'd0, 32'h0000_0000);
        queue_item(MODE_QUERY, 8'd0, 32'hFFFF_FFFF);
        queue_item(MODE_QUERY, 8'd0, 32'h8040_2010);     // tie keeps lower index
        queue_item(MODE_QUERY, 8'd0, 32'h8743_2317);     // only dropped bits differ in RGB; alpha still differs
        queue_item(MODE_QUERY, 8'd0, 32'h0E00_0000);     // alpha rounds down to 0
        queue_item(MODE_QUERY, 8'd0, 32'h7F7F_7F7F);
        settle();

        write_size(9'd1);
        queue_item(MODE_QUERY, 8'd0, 32'hFFFF_FFFF);
        // fill the whole palette so that any later size reads written slots
        for (int i = 0; i < PALETTE_DEPTH; i++)
            queue_item(MODE_WRITE, i[7:0], $urandom);
        settle();   // stimulus waits until every result is in

        // random phases: the extremes first, then mostly small sizes;
        // the last phase runs without idling
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: sz = 9'd511;                  // oversized, saturates
                1: sz = 9'd256;
                2: sz = 9'd255;
                3: sz = 9'd0;
                default: sz = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(0, 511))
                                                          : 9'($urandom_range(1, 24));
            endcase
            idle_on = (p != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
            write_size(sz);
            repeat (PHASE_ITEMS) random_item();
            settle();
        end

        repeat (20) @(posedge aclk);
        // nothing may be left waiting
        fault_count += nearest_due.size();
        if (fault_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
